// File: design/mtt_pkg.sv
package mtt_pkg;

   localparam int unsigned NUM_TIMERS = 16;
   localparam int unsigned CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int unsigned STEP_W     = 10;

   localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(10);

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] KIND_STARTED = 2'd0;
   localparam logic [1:0] KIND_FULL    = 2'd1;
   localparam logic [1:0] KIND_EXPIRED = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] owner;
      logic [31:0] duration_ms;
      logic [31:0] timer_id;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] result_id;
      logic [31:0] result_owner;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic        free;
      logic [31:0] id;
      logic [31:0] owner;
      logic [31:0] remaining;
   } slot_type;

   typedef struct packed {
      logic expire;
      logic place;
   } head_status_type;

endpackage

// File: design/mtt_cell.sv
module mtt_cell
   import mtt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     shift_en,
   input  slot_type slot_in,
   output slot_type slot_out
);

   logic        free_ff;
   logic [31:0] id_ff;
   logic [31:0] owner_ff;
   logic [31:0] remaining_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 1'b1;
      end else if (shift_en) begin
         free_ff <= slot_in.free;
      end
   end

   // contents only matter while the slot is active
   always_ff @(posedge clock) begin
      if (shift_en) begin
         id_ff        <= slot_in.id;
         owner_ff     <= slot_in.owner;
         remaining_ff <= slot_in.remaining;
      end
   end

   assign slot_out = '{free: free_ff, id: id_ff, owner: owner_ff, remaining: remaining_ff};

endmodule

// File: design/mtt_head.sv
module mtt_head
   import mtt_pkg::*;
(
   input  slot_type          slot_in,
   input  req_word_type      req,
   input  logic [STEP_W-1:0] tick_step,
   input  logic              placed,
   input  logic [31:0]       new_id,
   output slot_type          slot_out,
   output head_status_type   status
);

   logic [31:0] step_ext;
   logic        active;

   assign step_ext = {{(32 - STEP_W){1'b0}}, tick_step};
   assign active   = !slot_in.free;

   always_comb begin
      slot_out = slot_in;
      status   = '{expire: 1'b0, place: 1'b0};
      case (req.op)
         OP_TICK: begin
            if (active) begin
               if (slot_in.remaining <= step_ext) begin
                  slot_out.free = 1'b1;
                  status.expire = 1'b1;
               end else begin
                  slot_out.remaining = slot_in.remaining - step_ext;
               end
            end
         end
         OP_START: begin
            // first free slot in walk order takes the new timer
            if (slot_in.free && !placed) begin
               slot_out.free      = 1'b0;
               slot_out.id        = new_id;
               slot_out.owner     = req.owner;
               slot_out.remaining = req.duration_ms;
               status.place       = 1'b1;
            end
         end
         OP_CANCEL: begin
            if (active && slot_in.owner == req.owner &&
                (req.timer_id == 32'd0 || slot_in.id == req.timer_id)) begin
               slot_out.free = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: design/multi_timer_table_unit.sv
// channel | ports                          | word
// --------+--------------------------------+----------------------------------
// request | req_valid, req_stall, req_word | op, owner, duration_ms, timer_id
// response| rsp_valid, rsp_stall, rsp_word | kind, result_id, result_owner, last
// config  | csr_we, csr_wdata              | tick_step_ms, 10 bits
//
// one word at a time: the slot ring rotates once past the head cell, then
// the final response is handed off, then the next request is accepted
// a stalled response freezes the ring when a second expiry needs the
// output register; synchronous reset frees every slot and zeroes the id counter
module multi_timer_table_unit
   import mtt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word,
   input  logic              csr_we,
   input  logic [STEP_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [STEP_W-1:0] tick_step_ff;
   logic [31:0]       next_id_ff, next_id_in;
   logic [CNT_W-1:0]  walk_cnt_ff, walk_cnt_in;
   logic              placed_ff, placed_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   req_word_type      req_ff, req_in;
   rsp_word_type      pend_ff, pend_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   // slot ring
   slot_type          cell_q [NUM_TIMERS];
   slot_type          head_out;
   head_status_type   head_status;
   logic              shift_en;
   logic [31:0]       new_id;
   logic              out_free;
   logic              req_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // id counter skips zero on wrap
   assign new_id = (next_id_ff == 32'hFFFF_FFFF) ? 32'd1 : (next_id_ff + 32'd1);

   // cell i takes its neighbor's slot, the last cell takes the processed head
   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      slot_type cell_in;
      if (i == NUM_TIMERS - 1) begin : g_tail
         assign cell_in = head_out;
      end else begin : g_mid
         assign cell_in = cell_q[i+1];
      end
      mtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  (cell_in),
         .slot_out (cell_q[i])
      );
   end

   mtt_head u_head (
      .slot_in   (cell_q[0]),
      .req       (req_ff),
      .tick_step (tick_step_ff),
      .placed    (placed_ff),
      .new_id    (new_id),
      .slot_out  (head_out),
      .status    (head_status)
   );

   always_comb begin
      state_in      = state_ff;
      next_id_in    = next_id_ff;
      walk_cnt_in   = walk_cnt_ff;
      placed_in     = placed_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      req_in        = req_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      shift_en      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in      = req_word;
               walk_cnt_in = '0;
               placed_in   = 1'b0;
               // a start holds a table-full answer until a slot is found
               if (req_word.op == OP_START) begin
                  pend_valid_in = 1'b1;
                  pend_in       = '{kind: KIND_FULL, result_id: 32'd0,
                                    result_owner: req_word.owner, last: 1'b0};
               end else begin
                  pend_valid_in = 1'b0;
               end
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // a second expiry needs the held word moved out first
            if (!(head_status.expire && pend_valid_ff && !out_free)) begin
               shift_en    = 1'b1;
               walk_cnt_in = walk_cnt_ff + CNT_W'(1);
               if (head_status.expire) begin
                  if (pend_valid_ff) begin
                     rsp_word_in  = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = '{kind: KIND_EXPIRED, result_id: cell_q[0].id,
                                    result_owner: cell_q[0].owner, last: 1'b0};
               end
               if (head_status.place) begin
                  placed_in  = 1'b1;
                  next_id_in = new_id;
                  pend_in    = '{kind: KIND_STARTED, result_id: new_id,
                                 result_owner: req_ff.owner, last: 1'b0};
               end
               if (walk_cnt_ff == CNT_W'(NUM_TIMERS - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // final word of the request goes out flagged last
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_word_in      = pend_ff;
               rsp_word_in.last = 1'b1;
               rsp_valid_in     = 1'b1;
               pend_valid_in    = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_step_ff  <= TICK_STEP_RESET;
         next_id_ff    <= 32'd0;
         walk_cnt_ff   <= '0;
         placed_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_id_ff    <= next_id_in;
         walk_cnt_ff   <= walk_cnt_in;
         placed_ff     <= placed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            tick_step_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
